### design/avcflv_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and byte codes of the FLV AVC video tag packetizer.
package avcflv_pkg;

  // Stored SPS bytes, start code excluded.
  localparam int unsigned SPS_DEPTH = 32;
  localparam int unsigned SPS_AW    = $clog2(SPS_DEPTH);

  // Sequence header body: 13 fixed bytes, the SPS, then 3 PPS record bytes.
  localparam int unsigned SEQ_HDR_FIXED = 13;
  localparam int unsigned SEQ_REC_ID    = 6;   // profile, compat, level start here
  localparam int unsigned SEQ_OVERHEAD  = 16;
  localparam int unsigned FRAME_HDR_LEN = 9;
  localparam int unsigned IDX_W         = $clog2(SEQ_OVERHEAD + SPS_DEPTH);

  // NAL length limits, start code included.
  localparam int unsigned SPS_MIN_LEN   = 8;
  localparam int unsigned SPS_MAX_LEN   = SPS_DEPTH + 4;
  localparam int unsigned PPS_MIN_LEN   = 5;
  localparam int unsigned FRAME_MIN_LEN = 4;
  localparam int unsigned SC_LONG       = 4;
  localparam int unsigned SC_SHORT      = 3;
  localparam int unsigned SC_PROBE_POS  = 2;

  // NAL unit types.
  localparam logic [4:0] NAL_IDR = 5'd5;
  localparam logic [4:0] NAL_SPS = 5'd7;
  localparam logic [4:0] NAL_PPS = 5'd8;

  // Body byte codes.
  localparam logic [7:0] FLV_KEY_AVC   = 8'h17;
  localparam logic [7:0] FLV_INTER_AVC = 8'h27;
  localparam logic [7:0] AVC_SEQ_HDR   = 8'h00;
  localparam logic [7:0] AVC_NALU      = 8'h01;
  localparam logic [7:0] AVCC_VERSION  = 8'h01;
  localparam logic [7:0] AVCC_LEN_SIZE = 8'hFF;
  localparam logic [7:0] AVCC_NUM_SPS  = 8'hE1;
  localparam logic [7:0] AVCC_NUM_PPS  = 8'h01;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_NO_SPS   = 2'd1,
    ERR_SPS_LONG = 2'd2,
    ERR_SHORT    = 2'd3
  } err_e;

  // What one accepted byte makes the sequencer emit.
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_ERR,
    ACT_SEQ,
    ACT_FHDR,
    ACT_PAY
  } act_e;

  typedef struct packed {
    logic capture;
    logic eval;
    logic emit;
    act_e src;
  } dp_cmd_t;

  typedef struct packed {
    act_e plan;
    logic out_free;
    logic burst_end;
  } dp_stat_t;

endpackage

### design/avcflv_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM with registered read.
module avcflv_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### design/avcflv_dp.sv
`timescale 1ns / 1ps
// Datapath: NAL context registers, SPS store, body byte generator, output register.
module avcflv_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  avcflv_pkg::dp_cmd_t  cmd_i,
  output avcflv_pkg::dp_stat_t stat_o,
  input  logic [7:0]           in_byte_i,
  input  logic [4:0]           nal_type_i,
  input  logic [23:0]          nal_length_i,
  input  logic                 first_byte_i,
  input  logic                 m_ready_i,
  output logic                 m_valid_o,
  output logic [7:0]           out_byte_o,
  output logic                 body_first_o,
  output logic                 body_last_o,
  output logic                 body_kind_o,
  output logic [24:0]          body_size_o,
  output logic [1:0]           error_code_o,
  output logic                 run_last_o
);
  import avcflv_pkg::*;

  typedef enum logic [1:0] {M_IDLE, M_SPS, M_PPS, M_FRAME} mode_e;

  // captured input word
  logic [7:0]  in_b_q;
  logic [4:0]  in_t_q;
  logic [23:0] in_len_q;
  logic        in_fb_q;

  // NAL context
  logic [23:0] pos_q, pos_d;
  logic [23:0] cur_len_q, cur_len_d;
  logic [2:0]  skip_q, skip_d;
  mode_e       mode_q, mode_d;
  logic [5:0]  sps_len_q, sps_len_d;
  logic        sps_valid_q, sps_valid_d;
  logic        idr_q, idr_d;
  err_e        err_q, err_d;
  logic        pay_last_q, pay_last_d;
  logic        pay_kind_q, pay_kind_d;

  // sequencer index
  logic [IDX_W-1:0] idx_q, idx_d;

  // output register
  logic        m_valid_q, m_valid_d;
  logic [7:0]  out_byte_q;
  logic        out_first_q, out_last_q, out_kind_q, out_run_last_q;
  logic [24:0] out_size_q;
  err_e        out_err_q;

  act_e        plan;
  err_e        plan_err;
  logic        nal_last;
  logic [2:0]  skip_new;
  logic        ram_we;
  logic [SPS_AW-1:0] wr_addr, rd_addr;
  logic [7:0]  rd_data;
  logic        out_free, load;

  logic [IDX_W-1:0] seq_end;
  logic [23:0] pps_len, plen;
  logic [24:0] seq_size, frame_size;

  logic [7:0]  res_byte;
  logic        res_first, res_last, res_kind, res_run_last;
  logic [24:0] res_size;
  err_e        res_err;
  logic        burst_end;

  assign nal_last = (pos_q == cur_len_q - 24'd1);
  assign skip_new = (in_b_q == 8'h00) ? 3'(SC_LONG) : 3'(SC_SHORT);
  assign wr_addr  = SPS_AW'(pos_q - 24'd4);

  // what this byte causes and how it moves the NAL context
  always_comb begin
    pos_d       = pos_q;
    cur_len_d   = cur_len_q;
    skip_d      = skip_q;
    mode_d      = mode_q;
    sps_len_d   = sps_len_q;
    sps_valid_d = sps_valid_q;
    idr_d       = idr_q;
    err_d       = err_q;
    pay_last_d  = pay_last_q;
    pay_kind_d  = pay_kind_q;
    plan        = ACT_NONE;
    plan_err    = ERR_NONE;
    ram_we      = 1'b0;

    if (in_fb_q) begin
      case (in_t_q)
        NAL_SPS: begin
          if (in_len_q < 24'(SPS_MIN_LEN)) plan_err = ERR_SHORT;
          else if (in_len_q > 24'(SPS_MAX_LEN)) plan_err = ERR_SPS_LONG;
        end
        NAL_PPS: begin
          if (!sps_valid_q) plan_err = ERR_NO_SPS;
          else if (in_len_q < 24'(PPS_MIN_LEN)) plan_err = ERR_SHORT;
        end
        default: begin
          if (in_len_q < 24'(FRAME_MIN_LEN)) plan_err = ERR_SHORT;
        end
      endcase
      if (plan_err != ERR_NONE) plan = ACT_ERR;
      else if (in_t_q == NAL_PPS) plan = ACT_SEQ;
    end else if (mode_q == M_FRAME && pos_q == 24'(SC_PROBE_POS)) begin
      // start code length is known on the third byte
      if (cur_len_q < 24'(skip_new) + 24'd1) begin
        plan_err = ERR_SHORT;
        plan     = ACT_ERR;
      end else begin
        plan = ACT_FHDR;
      end
    end else if (mode_q == M_PPS && pos_q >= 24'(SC_LONG)) begin
      plan = ACT_PAY;
    end else if (mode_q == M_FRAME && skip_q != 3'd0 && pos_q >= 24'(skip_q)) begin
      plan = ACT_PAY;
    end

    if (cmd_i.eval) begin
      err_d = plan_err;
      if (in_fb_q) begin
        mode_d    = M_IDLE;
        pos_d     = '0;
        cur_len_d = in_len_q;
        skip_d    = '0;
        if (plan_err == ERR_NONE) begin
          pos_d = 24'd1;
          case (in_t_q)
            NAL_SPS: begin
              mode_d      = M_SPS;
              skip_d      = 3'(SC_LONG);
              sps_valid_d = 1'b0;
            end
            NAL_PPS: begin
              mode_d = M_PPS;
              skip_d = 3'(SC_LONG);
            end
            default: begin
              mode_d = M_FRAME;
              idr_d  = (in_t_q == NAL_IDR);
            end
          endcase
        end
      end else if (mode_q != M_IDLE) begin
        if (plan == ACT_ERR) begin
          mode_d = M_IDLE;
        end else begin
          if (mode_q == M_SPS) begin
            ram_we = (pos_q >= 24'(SC_LONG));
            if (nal_last) begin
              sps_len_d   = 6'(cur_len_q - 24'd4);
              sps_valid_d = 1'b1;
            end
          end
          if (mode_q == M_FRAME && pos_q == 24'(SC_PROBE_POS)) skip_d = skip_new;
          pay_last_d = nal_last;
          pay_kind_d = (mode_q == M_FRAME);
          if (nal_last) mode_d = M_IDLE;
          pos_d = pos_q + 24'd1;
        end
      end
    end
  end

  // body byte generator
  assign seq_end    = IDX_W'(SEQ_HDR_FIXED) + IDX_W'(sps_len_q);
  assign pps_len    = cur_len_q - 24'd4;
  assign plen       = cur_len_q - 24'(skip_q);
  assign seq_size   = 25'(SEQ_OVERHEAD) + 25'(sps_len_q) + 25'(pps_len);
  assign frame_size = 25'(FRAME_HDR_LEN) + 25'(plen);

  always_comb begin
    res_byte     = '0;
    res_first    = 1'b0;
    res_last     = 1'b0;
    res_kind     = 1'b0;
    res_size     = '0;
    res_err      = ERR_NONE;
    res_run_last = 1'b0;
    burst_end    = 1'b1;
    case (cmd_i.src)
      ACT_ERR: begin
        res_err      = err_q;
        res_run_last = 1'b1;
      end
      ACT_SEQ: begin
        burst_end = (idx_q == seq_end + IDX_W'(2));
        if (idx_q < IDX_W'(SEQ_HDR_FIXED)) begin
          case (idx_q[3:0])
            4'd0: begin
              res_byte  = FLV_KEY_AVC;
              res_first = 1'b1;
              res_size  = seq_size;
            end
            4'd5:              res_byte = AVCC_VERSION;
            4'd6, 4'd7, 4'd8:  res_byte = rd_data;
            4'd9:              res_byte = AVCC_LEN_SIZE;
            4'd10:             res_byte = AVCC_NUM_SPS;
            4'd12:             res_byte = 8'(sps_len_q);
            default:           res_byte = AVC_SEQ_HDR;
          endcase
        end else if (idx_q < seq_end) begin
          res_byte = rd_data;
        end else if (idx_q == seq_end) begin
          res_byte = AVCC_NUM_PPS;
        end else if (idx_q == seq_end + IDX_W'(1)) begin
          res_byte = pps_len[15:8];
        end else begin
          res_byte     = pps_len[7:0];
          res_run_last = 1'b1;
        end
      end
      ACT_FHDR: begin
        res_kind  = 1'b1;
        burst_end = (idx_q == IDX_W'(FRAME_HDR_LEN - 1));
        case (idx_q[3:0])
          4'd0: begin
            res_byte  = idr_q ? FLV_KEY_AVC : FLV_INTER_AVC;
            res_first = 1'b1;
            res_size  = frame_size;
          end
          4'd1: res_byte = AVC_NALU;
          4'd6: res_byte = plen[23:16];
          4'd7: res_byte = plen[15:8];
          4'd8: begin
            res_byte     = plen[7:0];
            res_run_last = 1'b1;
          end
          default: res_byte = 8'h00;   // composition time, length top byte
        endcase
      end
      ACT_PAY: begin
        res_byte     = in_b_q;
        res_last     = pay_last_q;
        res_kind     = pay_kind_q;
        res_run_last = 1'b1;
      end
      default: ;
    endcase
  end

  assign out_free  = !m_valid_q || m_ready_i;
  assign load      = cmd_i.emit && out_free;
  assign m_valid_d = load ? 1'b1 : (m_ready_i ? 1'b0 : m_valid_q);

  always_comb begin
    if (cmd_i.eval) idx_d = '0;
    else if (load) idx_d = idx_q + IDX_W'(1);
    else idx_d = idx_q;
  end

  // read one index ahead so the stored byte is ready when its index comes up
  always_comb begin
    if (idx_d < IDX_W'(SEQ_HDR_FIXED)) rd_addr = SPS_AW'(idx_d - IDX_W'(SEQ_REC_ID - 1));
    else rd_addr = SPS_AW'(idx_d - IDX_W'(SEQ_HDR_FIXED));
  end

  avcflv_ram #(
    .WIDTH (8),
    .DEPTH (SPS_DEPTH)
  ) u_sps_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_addr),
    .wdata_i (in_b_q),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      cur_len_q   <= '0;
      skip_q      <= '0;
      mode_q      <= M_IDLE;
      sps_len_q   <= '0;
      sps_valid_q <= 1'b0;
      idr_q       <= 1'b0;
      idx_q       <= '0;
      m_valid_q   <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      cur_len_q   <= cur_len_d;
      skip_q      <= skip_d;
      mode_q      <= mode_d;
      sps_len_q   <= sps_len_d;
      sps_valid_q <= sps_valid_d;
      idr_q       <= idr_d;
      idx_q       <= idx_d;
      m_valid_q   <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      in_b_q   <= in_byte_i;
      in_t_q   <= nal_type_i;
      in_len_q <= nal_length_i;
      in_fb_q  <= first_byte_i;
    end
    err_q      <= err_d;
    pay_last_q <= pay_last_d;
    pay_kind_q <= pay_kind_d;
    if (load) begin
      out_byte_q     <= res_byte;
      out_first_q    <= res_first;
      out_last_q     <= res_last;
      out_kind_q     <= res_kind;
      out_size_q     <= res_size;
      out_err_q      <= res_err;
      out_run_last_q <= res_run_last;
    end
  end

  assign stat_o.plan      = plan;
  assign stat_o.out_free  = out_free;
  assign stat_o.burst_end = burst_end;

  assign m_valid_o    = m_valid_q;
  assign out_byte_o   = out_byte_q;
  assign body_first_o = out_first_q;
  assign body_last_o  = out_last_q;
  assign body_kind_o  = out_kind_q;
  assign body_size_o  = out_size_q;
  assign error_code_o = out_err_q;
  assign run_last_o   = out_run_last_q;

endmodule

### design/avcflv_ctrl.sv
`timescale 1ns / 1ps
// Controller: accepts a byte, has it evaluated, then sequences the output words it causes.
module avcflv_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  avcflv_pkg::dp_stat_t stat_i,
  output avcflv_pkg::dp_cmd_t  cmd_o
);
  import avcflv_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_ERR,
    S_SEQ,
    S_FHDR,
    S_PAY
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EVAL;
      end
      S_EVAL: begin
        case (stat_i.plan)
          ACT_ERR:  state_d = S_ERR;
          ACT_SEQ:  state_d = S_SEQ;
          ACT_FHDR: state_d = S_FHDR;
          ACT_PAY:  state_d = S_PAY;
          default:  state_d = S_IDLE;
        endcase
      end
      S_ERR, S_SEQ, S_FHDR, S_PAY: begin
        if (stat_i.out_free && stat_i.burst_end) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    cmd_o.capture = (state_q == S_IDLE) && in_valid_i;
    cmd_o.eval    = (state_q == S_EVAL);
    cmd_o.emit    = state_q inside {S_ERR, S_SEQ, S_FHDR, S_PAY};
    case (state_q)
      S_ERR:   cmd_o.src = ACT_ERR;
      S_SEQ:   cmd_o.src = ACT_SEQ;
      S_FHDR:  cmd_o.src = ACT_FHDR;
      S_PAY:   cmd_o.src = ACT_PAY;
      default: cmd_o.src = ACT_NONE;
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule

### design/avc_nal_to_flv_video_tag.sv
`timescale 1ns / 1ps
// Top level of the H.264 Annex-B NAL to FLV AVC video tag body packetizer.
// Takes one NAL byte per input word and emits FLV video tag body bytes, one per
// output word. A byte is taken in one cycle and evaluated in the next. The
// output sequencer emits one word per cycle while the output side is ready:
// the first byte of a PPS causes the sequence header, the third byte of a
// slice NAL the frame header, and an error one error word. An output register
// separates the two sides, so the next byte is taken while a finished word
// still waits. The SPS store needs no clearing after reset. tlast on the input
// is not used: the length on the first byte sets where each NAL ends.
module avc_nal_to_flv_video_tag (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // in_byte[7:0], nal_length[31:8]
  input  logic [5:0]  s_axis_tuser,   // nal_type[4:0], first_byte[5]
  input  logic        s_axis_tlast,   // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // out_byte[7:0], body_size[32:8], zero[39:33]
  output logic [4:0]  m_axis_tuser,   // body_first[0], body_kind[1], error_code[3:2],
                                      // run_last[4]
  output logic        m_axis_tlast    // body_last
);
  import avcflv_pkg::*;

  dp_cmd_t     dp_cmd;
  dp_stat_t    dp_stat;
  logic [7:0]  out_byte;
  logic        body_first, body_last, body_kind, run_last;
  logic [24:0] body_size;
  logic [1:0]  error_code;

  avcflv_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (dp_stat),
    .cmd_o      (dp_cmd)
  );

  avcflv_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (dp_cmd),
    .stat_o       (dp_stat),
    .in_byte_i    (s_axis_tdata[7:0]),
    .nal_type_i   (s_axis_tuser[4:0]),
    .nal_length_i (s_axis_tdata[31:8]),
    .first_byte_i (s_axis_tuser[5]),
    .m_ready_i    (m_axis_tready),
    .m_valid_o    (m_axis_tvalid),
    .out_byte_o   (out_byte),
    .body_first_o (body_first),
    .body_last_o  (body_last),
    .body_kind_o  (body_kind),
    .body_size_o  (body_size),
    .error_code_o (error_code),
    .run_last_o   (run_last)
  );

  assign m_axis_tdata = {7'd0, body_size, out_byte};
  assign m_axis_tuser = {run_last, error_code, body_kind, body_first};
  assign m_axis_tlast = body_last;

  // one byte is evaluated at a time
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken while a byte is still being evaluated");

  // an error word stands alone and ends its run
  a_err_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[3:2] != ERR_NONE) |->
      (m_axis_tuser[4] && !m_axis_tuser[0] && !m_axis_tlast))
    else $error("error word carries body flags");

  // a body opening word carries its size
  a_first_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[32:8] != 25'd0))
    else $error("body start without a size");

endmodule
